@@ rtl/integer_matrix_multiply_unit_assert.svh @@
// Assertion macros shared by the matrix multiply unit modules
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// same-cycle implication
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/imm_pkg.sv @@
// Shared constants, types and helpers for the integer matrix multiply unit
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int DIM_W   = 4;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_W-1:0] CFG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_MISM
  } state_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              out_load;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic              out_last;
    logic              out_mism;
  } ctrl_t;

  // saturate a dimension register to 1..MAX_DIM and return it minus one
  function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (d == '0) d = DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) d = DIM_W'(MAX_DIM);
    d = d - DIM_W'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/integer_matrix_multiply_unit.sv @@
// Top level of the integer matrix multiply unit
//
//   channel  signals                               direction
//   cfg      cfg_we cfg_index cfg_data             in, write only
//   in       in_valid/in_ready cmd elem_*          in
//   out      out_valid/out_ready out_* last mism   out
//
// A compute transfer is served by the single shared multiply-accumulate unit, fed one
// A and one B memory read per cycle while the sequencer is in its run state; a
// mismatch yields one result flagged as a mismatch.
// Output stalls stretch the walk; intake is held until the last result is registered.
// Reset (rst, synchronous) clears control state and sets every dimension to 1.
// Memory contents are not cleared.
module integer_matrix_multiply_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [imm_pkg::CFG_W-1:0]          cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [imm_pkg::CMD_W-1:0]          cmd,
  input  logic [imm_pkg::IDX_W-1:0]          elem_row,
  input  logic [imm_pkg::IDX_W-1:0]          elem_col,
  input  logic signed [imm_pkg::DATA_W-1:0]  elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [imm_pkg::IDX_W-1:0]          out_row,
  output logic [imm_pkg::IDX_W-1:0]          out_col,
  output logic signed [imm_pkg::DATA_W-1:0]  out_value,
  output logic                               last,
  output logic                               mismatch
);

  imm_pkg::ctrl_t             ctrl;
  logic                       out_free;
  logic [imm_pkg::DATA_W-1:0] value_u;

  imm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .elem_row  (elem_row),
    .elem_col  (elem_col),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  imm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .elem_value (unsigned'(elem_value)),
    .out_ready  (out_ready),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (value_u),
    .out_last   (last),
    .out_mism   (mismatch)
  );

  assign out_value = signed'(value_u);

endmodule

@@ rtl/imm_seq.sv @@
// Sequencer: configuration registers, intake control and the row/col/k walk
`include "integer_matrix_multiply_unit_assert.svh"
module imm_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [imm_pkg::CFG_W-1:0]   cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imm_pkg::CMD_W-1:0]   cmd,
  input  logic [imm_pkg::IDX_W-1:0]   elem_row,
  input  logic [imm_pkg::IDX_W-1:0]   elem_col,
  input  logic                        out_free,
  output imm_pkg::ctrl_t              ctrl
);

  imm_pkg::state_t state, state_next;
  logic [imm_pkg::DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [imm_pkg::IDX_W-1:0] row, row_next, col, col_next, k, k_next;
  logic                      drain, drain_next;
  logic [imm_pkg::IDX_W-1:0] ar_m1, inner_m1, br_m1, bc_m1;
  logic                      in_range;
  logic                      at_last;

  assign ar_m1    = imm_pkg::dim_m1(a_rows);
  assign inner_m1 = imm_pkg::dim_m1(a_cols);
  assign br_m1    = imm_pkg::dim_m1(b_rows);
  assign bc_m1    = imm_pkg::dim_m1(b_cols);
  assign in_range = ({1'b0, elem_row} < (imm_pkg::IDX_W+1)'(imm_pkg::MAX_DIM)) &&
                    ({1'b0, elem_col} < (imm_pkg::IDX_W+1)'(imm_pkg::MAX_DIM));
  assign at_last  = (row == ar_m1) && (col == bc_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= imm_pkg::DIM_W'(1);
      a_cols <= imm_pkg::DIM_W'(1);
      b_rows <= imm_pkg::DIM_W'(1);
      b_cols <= imm_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        imm_pkg::CFG_A_ROWS: a_rows <= cfg_data;
        imm_pkg::CFG_A_COLS: a_cols <= cfg_data;
        imm_pkg::CFG_B_ROWS: b_rows <= cfg_data;
        imm_pkg::CFG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    k_next        = k;
    drain_next    = drain;
    in_ready      = (state == imm_pkg::ST_IDLE);
    ctrl          = '0;
    ctrl.wr_addr  = {elem_row, elem_col};
    ctrl.a_addr   = {row, k};
    ctrl.b_addr   = {k, col};
    ctrl.out_row  = row;
    ctrl.out_col  = col;
    ctrl.out_last = at_last;
    case (state)
      imm_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            imm_pkg::CMD_LOAD_A: ctrl.wr_a = in_range;
            imm_pkg::CMD_LOAD_B: ctrl.wr_b = in_range;
            imm_pkg::CMD_COMPUTE: begin
              row_next   = '0;
              col_next   = '0;
              k_next     = '0;
              state_next = (inner_m1 != br_m1) ? imm_pkg::ST_MISM : imm_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      imm_pkg::ST_RUN: begin
        ctrl.rd_en    = 1'b1;
        ctrl.rd_first = (k == '0);
        if (k == inner_m1) begin
          k_next     = '0;
          drain_next = 1'b0;
          state_next = imm_pkg::ST_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      imm_pkg::ST_DRAIN: begin
        // read and multiply stages still in flight
        drain_next = 1'b1;
        if (drain) state_next = imm_pkg::ST_EMIT;
      end
      imm_pkg::ST_EMIT: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          if (at_last) begin
            state_next = imm_pkg::ST_IDLE;
          end else begin
            state_next = imm_pkg::ST_RUN;
            if (col == bc_m1) begin
              col_next = '0;
              row_next = row + 1'b1;
            end else begin
              col_next = col + 1'b1;
            end
          end
        end
      end
      imm_pkg::ST_MISM: begin
        ctrl.out_row  = '0;
        ctrl.out_col  = '0;
        ctrl.out_last = 1'b1;
        ctrl.out_mism = 1'b1;
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = imm_pkg::ST_IDLE;
        end
      end
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  `IMM_ASSERT_NEXT(a_mism_route, state == imm_pkg::ST_IDLE && in_valid && cmd == imm_pkg::CMD_COMPUTE && inner_m1 != br_m1, state == imm_pkg::ST_MISM, "dimension mismatch not routed")
  `IMM_ASSERT_NOW(a_run_bound, state == imm_pkg::ST_RUN, k <= inner_m1, "inner index past dimension")
  `IMM_ASSERT_NOW(a_emit_free, ctrl.out_load, out_free, "result loaded while output busy")

endmodule

@@ rtl/imm_dp.sv @@
// Datapath: A and B memories, shared multiply-accumulate unit, output register
`include "integer_matrix_multiply_unit_assert.svh"
module imm_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  imm_pkg::ctrl_t              ctrl,
  input  logic [imm_pkg::DATA_W-1:0]  elem_value,
  input  logic                        out_ready,
  output logic                        out_free,
  output logic                        out_valid,
  output logic [imm_pkg::IDX_W-1:0]   out_row,
  output logic [imm_pkg::IDX_W-1:0]   out_col,
  output logic [imm_pkg::DATA_W-1:0]  out_value,
  output logic                        out_last,
  output logic                        out_mism
);

  logic [imm_pkg::DATA_W-1:0] mem_a [0:imm_pkg::DEPTH-1];
  logic [imm_pkg::DATA_W-1:0] mem_b [0:imm_pkg::DEPTH-1];
  logic [imm_pkg::DATA_W-1:0] rd_a, rd_b, prod, acc;
  logic                       v1, f1, v2, f2;

  always_ff @(posedge clk) begin
    if (ctrl.wr_a) mem_a[ctrl.wr_addr] <= elem_value;
    rd_a <= mem_a[ctrl.a_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_b) mem_b[ctrl.wr_addr] <= elem_value;
    rd_b <= mem_b[ctrl.b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      f1 <= 1'b0;
      v2 <= 1'b0;
      f2 <= 1'b0;
    end else begin
      v1 <= ctrl.rd_en;
      f1 <= ctrl.rd_first;
      v2 <= v1;
      f2 <= f1;
    end
  end

  // low 32 bits of the product are all the wrapped sum needs
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
    if (v2) acc <= f2 ? prod : acc + prod;
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_row   <= ctrl.out_row;
      out_col   <= ctrl.out_col;
      out_value <= ctrl.out_mism ? '0 : acc;
      out_last  <= ctrl.out_last;
      out_mism  <= ctrl.out_mism;
    end
  end

  `IMM_ASSERT_NOW(a_no_rw_overlap, ctrl.rd_en, !ctrl.wr_a && !ctrl.wr_b, "load during product walk")
  `IMM_ASSERT_NEXT(a_mism_zero, ctrl.out_load && ctrl.out_mism, out_valid && out_value == '0 && out_last && out_mism, "bad mismatch result")
  `IMM_ASSERT_NOW(a_load_free, ctrl.out_load, !out_valid || out_ready, "output register overwritten")

endmodule

@@ dv/integer_matrix_multiply_unit_checker.sv @@
// Checker for the integer matrix multiply unit: tracks loads, predicts products, compares results
module integer_matrix_multiply_unit_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [imm_pkg::CFG_W-1:0]         cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [imm_pkg::CMD_W-1:0]         cmd,
  input  logic [imm_pkg::IDX_W-1:0]         elem_row,
  input  logic [imm_pkg::IDX_W-1:0]         elem_col,
  input  logic signed [imm_pkg::DATA_W-1:0] elem_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [imm_pkg::IDX_W-1:0]         out_row,
  input  logic [imm_pkg::IDX_W-1:0]         out_col,
  input  logic signed [imm_pkg::DATA_W-1:0] out_value,
  input  logic                              last,
  input  logic                              mismatch,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [imm_pkg::IDX_W-1:0]  row;
    logic [imm_pkg::IDX_W-1:0]  col;
    logic [imm_pkg::DATA_W-1:0] value;
    logic                       last;
    logic                       mism;
  } product_elem_t;

  product_elem_t              product_q[$];
  logic [imm_pkg::DATA_W-1:0] a_mem [imm_pkg::DEPTH];
  logic [imm_pkg::DATA_W-1:0] b_mem [imm_pkg::DEPTH];
  logic [imm_pkg::DIM_W-1:0]  dim_reg [4];
  product_elem_t              got;
  product_elem_t              want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned sat_dim(input logic [imm_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > imm_pkg::DIM_W'(imm_pkg::MAX_DIM)) return imm_pkg::MAX_DIM;
    return 32'(v);
  endfunction

  function automatic string show(input product_elem_t e);
    return $sformatf("row %0d col %0d value %h last %b mismatch %b",
                     e.row, e.col, e.value, e.last, e.mism);
  endfunction

  // queue every product element a compute transfer produces
  function automatic void predict_product();
    int unsigned                ar;
    int unsigned                inner;
    int unsigned                br;
    int unsigned                bc;
    logic [imm_pkg::DATA_W-1:0] acc;
    ar    = sat_dim(dim_reg[imm_pkg::CFG_A_ROWS]);
    inner = sat_dim(dim_reg[imm_pkg::CFG_A_COLS]);
    br    = sat_dim(dim_reg[imm_pkg::CFG_B_ROWS]);
    bc    = sat_dim(dim_reg[imm_pkg::CFG_B_COLS]);
    if (inner != br) begin
      product_q.push_back('{row: '0, col: '0, value: '0, last: 1'b1, mism: 1'b1});
      return;
    end
    for (int r = 0; r < ar; r++) begin
      for (int c = 0; c < bc; c++) begin
        acc = '0;
        for (int i = 0; i < inner; i++)
          acc = acc + a_mem[r * imm_pkg::MAX_DIM + i] * b_mem[i * imm_pkg::MAX_DIM + c];
        product_q.push_back('{row: imm_pkg::IDX_W'(r), col: imm_pkg::IDX_W'(c), value: acc,
                              last: (r == ar - 1 && c == bc - 1), mism: 1'b0});
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (dim_reg[k]) dim_reg[k] = imm_pkg::DIM_W'(1);
    end else begin
      if (cfg_we) dim_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        case (cmd)
          imm_pkg::CMD_LOAD_A:  a_mem[{elem_row, elem_col}] = elem_value;
          imm_pkg::CMD_LOAD_B:  b_mem[{elem_row, elem_col}] = elem_value;
          imm_pkg::CMD_COMPUTE: predict_product();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{row: out_row, col: out_col, value: out_value, last: last, mism: mismatch};
        if (product_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR %0t: result transfer with nothing pending: %s", $realtime, show(got));
        end else begin
          want = product_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
              got.last !== want.last || got.mism !== want.mism) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR %0t: expected %s, got %s", $realtime, show(want), show(got));
          end
        end
      end
    end
    pending = product_q.size();
  end

endmodule

@@ dv/integer_matrix_multiply_unit_tb.sv @@
// Testbench top for the integer matrix multiply unit: clock, reset, stimulus and verdict
module integer_matrix_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [imm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 6;
  localparam int SETTLE_CYCLES   = 16;

  // raw register values per phase: a_rows, a_cols, b_rows, b_cols
  localparam logic [imm_pkg::DIM_W-1:0] PHASE_DIMS [NUM_PHASES][4] = '{
    '{4'd2,  4'd3,  4'd3,  4'd2},
    '{4'd0,  4'd0,  4'd0,  4'd0},
    '{4'd3,  4'd4,  4'd5,  4'd2},
    '{4'd1,  4'd15, 4'd15, 4'd1},
    '{4'd9,  4'd2,  4'd2,  4'd1},
    '{4'd4,  4'd15, 4'd7,  4'd3},
    '{4'd1,  4'd1,  4'd1,  4'd15},
    '{4'd3,  4'd2,  4'd2,  4'd4}
  };
  localparam int SEND_IDLE  [NUM_PHASES] = '{10, 0,  69, 0, 69, 0,  10, 0};
  localparam int RECV_STALL [NUM_PHASES] = '{10, 69, 0,  0, 0,  69, 10, 69};

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [imm_pkg::CFG_W-1:0]         cfg_index = '0;
  logic [imm_pkg::DIM_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [imm_pkg::CMD_W-1:0]         cmd = imm_pkg::CMD_LOAD_A;
  logic [imm_pkg::IDX_W-1:0]         elem_row = '0;
  logic [imm_pkg::IDX_W-1:0]         elem_col = '0;
  logic signed [imm_pkg::DATA_W-1:0] elem_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [imm_pkg::IDX_W-1:0]         out_row;
  logic [imm_pkg::IDX_W-1:0]         out_col;
  logic signed [imm_pkg::DATA_W-1:0] out_value;
  logic                              last;
  logic                              mismatch;
  int                                fail_count;
  int                                pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned eff_ar = 1;
  int unsigned eff_inner = 1;
  int unsigned eff_br = 1;
  int unsigned eff_bc = 1;
  bit          a_written [imm_pkg::DEPTH];
  bit          b_written [imm_pkg::DEPTH];

  integer_matrix_multiply_unit dut (.*);

  integer_matrix_multiply_unit_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned sat_dim(input logic [imm_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > imm_pkg::DIM_W'(imm_pkg::MAX_DIM)) return imm_pkg::MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [imm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return imm_pkg::DATA_W'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [imm_pkg::CMD_W-1:0] c, input int unsigned r,
                           input int unsigned col, input logic [imm_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    elem_row   <= imm_pkg::IDX_W'(r);
    elem_col   <= imm_pkg::IDX_W'(col);
    elem_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == imm_pkg::CMD_LOAD_A) a_written[r * imm_pkg::MAX_DIM + col] = 1'b1;
    if (c == imm_pkg::CMD_LOAD_B) b_written[r * imm_pkg::MAX_DIM + col] = 1'b1;
  endtask

  // load any operand a matching product will read that has not been written yet, then send compute
  task automatic run_compute();
    if (eff_inner == eff_br) begin
      for (int r = 0; r < eff_ar; r++)
        for (int i = 0; i < eff_inner; i++)
          if (!a_written[r * imm_pkg::MAX_DIM + i])
            send_item(imm_pkg::CMD_LOAD_A, r, i, pick_value());
      for (int i = 0; i < eff_br; i++)
        for (int c = 0; c < eff_bc; c++)
          if (!b_written[i * imm_pkg::MAX_DIM + c])
            send_item(imm_pkg::CMD_LOAD_B, i, c, pick_value());
    end
    send_item(imm_pkg::CMD_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned rows;
    int unsigned cols;
    bit          is_b;
    pick = $urandom_range(99);
    if (pick < 75) begin
      is_b = (pick >= 40);
      rows = is_b ? eff_br : eff_ar;
      cols = is_b ? eff_bc : eff_inner;
      if ($urandom_range(9) < 7)
        send_item(is_b ? imm_pkg::CMD_LOAD_B : imm_pkg::CMD_LOAD_A, $urandom_range(rows - 1),
                  $urandom_range(cols - 1), pick_value());
      else
        send_item(is_b ? imm_pkg::CMD_LOAD_B : imm_pkg::CMD_LOAD_A, $urandom_range(7),
                  $urandom_range(7), pick_value());
    end else if (pick < 92) begin
      run_compute();
    end else begin
      send_item(CMD_UNUSED, $urandom_range(7), $urandom_range(7), $urandom);
    end
  endtask

  task automatic write_reg(input logic [imm_pkg::CFG_W-1:0] idx,
                           input logic [imm_pkg::DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_phase(input int p);
    write_reg(imm_pkg::CFG_A_ROWS, PHASE_DIMS[p][imm_pkg::CFG_A_ROWS]);
    write_reg(imm_pkg::CFG_A_COLS, PHASE_DIMS[p][imm_pkg::CFG_A_COLS]);
    write_reg(imm_pkg::CFG_B_ROWS, PHASE_DIMS[p][imm_pkg::CFG_B_ROWS]);
    write_reg(imm_pkg::CFG_B_COLS, PHASE_DIMS[p][imm_pkg::CFG_B_COLS]);
    cfg_we    <= 1'b0;
    eff_ar    = sat_dim(PHASE_DIMS[p][imm_pkg::CFG_A_ROWS]);
    eff_inner = sat_dim(PHASE_DIMS[p][imm_pkg::CFG_A_COLS]);
    eff_br    = sat_dim(PHASE_DIMS[p][imm_pkg::CFG_B_ROWS]);
    eff_bc    = sat_dim(PHASE_DIMS[p][imm_pkg::CFG_B_COLS]);
    idle_pct  = SEND_IDLE[p];
    stall_pct = RECV_STALL[p];
  endtask

  // wait for every pending result transfer, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 1x1 at reset dimensions: value extremes, wrap, unused command, corner indices
    send_item(imm_pkg::CMD_LOAD_A, 0, 0, 32'h7fff_ffff);
    send_item(imm_pkg::CMD_LOAD_B, 0, 0, 32'h7fff_ffff);
    send_item(imm_pkg::CMD_COMPUTE, 0, 0, 32'h0);
    send_item(imm_pkg::CMD_LOAD_A, 0, 0, 32'h8000_0000);
    send_item(imm_pkg::CMD_COMPUTE, 7, 7, 32'hffff_ffff);
    send_item(imm_pkg::CMD_LOAD_B, 0, 0, 32'hffff_ffff);
    send_item(imm_pkg::CMD_LOAD_A, 7, 7, 32'h1234_5678);
    send_item(CMD_UNUSED, 0, 0, 32'h5555_5555);
    send_item(imm_pkg::CMD_COMPUTE, 0, 0, 32'h0);
    send_item(imm_pkg::CMD_LOAD_B, 7, 7, 32'h8000_0000);
    send_item(imm_pkg::CMD_LOAD_A, 0, 0, 32'h0);
    send_item(imm_pkg::CMD_COMPUTE, 0, 0, 32'h0);
    send_item(imm_pkg::CMD_LOAD_A, 0, 0, 32'hffff_ffff);
    send_item(imm_pkg::CMD_COMPUTE, 3, 4, 32'hffff_ffff);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      program_phase(p);
      run_compute();
      repeat (ITEMS_PER_PHASE) random_item();
    end
    settle();

    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/imm_pkg.sv
rtl/imm_seq.sv
rtl/imm_dp.sv
rtl/integer_matrix_multiply_unit.sv
dv/integer_matrix_multiply_unit_checker.sv
dv/integer_matrix_multiply_unit_tb.sv
